### src/mvgb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mvgb_pkg: shared types and constants of the motion vector grid binner
// Field widths, configuration register indexes, controller states and the
// command/status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package mvgb_pkg;

    // Fixed field widths
    localparam int COORD_W    = 13;   // dst_x, dst_y, read_index, cell_index
    localparam int BLK_W      = 5;    // blk_w, blk_h
    localparam int MOTION_W   = 16;   // motion vector and cell sums
    localparam int OUT_W      = 8;    // clamped cell motion
    localparam int GRID_W     = 10;   // grid_cols, grid_rows
    localparam int WEIGHT_W   = 4;    // (31*31)/64 fits in four bits
    localparam int IDX_FULL_W = COORD_W + GRID_W + 1;  // row*cols + col

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'b1;

    localparam logic [GRID_W-1:0] GRID_COLS_RST = 10'd120;
    localparam logic [GRID_W-1:0] GRID_ROWS_RST = 10'd67;

    // Operation codes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Controller states, one-hot
    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_DIV    = 9'b000000100,
        S_FIX    = 9'b000001000,
        S_IDX    = 9'b000010000,
        S_ISSUE  = 9'b000100000,
        S_WR     = 9'b001000000,
        S_RISSUE = 9'b010000000,
        S_ROUT   = 9'b100000000
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic cap;       // capture the input transfer
        logic div_step;  // quotient estimate, weight and weighted motion
        logic fix_step;  // quotient correction, sign of the motion
        logic idx_step;  // cell number and add checks
        logic rd_add;    // read the cell for read-modify-write
        logic wr_add;    // write the updated sums
        logic rd_cell;   // read the cell for a read item
        logic out_load;  // load the result register and clear the cell
        logic clr_wr;    // clearing pass write
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_op;     // operation of the offered item
        logic add_ok;    // add item touches a cell
        logic ridx_ok;   // read index lies inside the store
        logic clr_last;  // last entry of the clearing pass
        logic out_free;  // result register can take a new result
    } t_sts;

endpackage
`default_nettype wire

### src/motion_vector_grid_binner_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// motion_vector_grid_binner_top: motion vector grid binner
// Accumulates weighted motion vectors into 16-bit X/Y sums per grid cell and
// returns clamped, cleared cell values on read.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one item per transfer:
//   operation 0 adds a vector, operation 1 reads and clears one cell.
//   Output channel (o_out_valid / i_out_ready) returns one result per read;
//   adds return nothing.
//   Configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes
//   grid_cols (index 0) or grid_rows (index 1); write only while idle.
// Timing:
//   An add steps through divide, correct, index, store read and store write
//   before the next transfer is possible; one that touches no cell issues no
//   store read and skips the store write. A read steps through a store read
//   and an output step that loads the result register. Both sequences are set
//   by the sequencer and the registered read of the single cell store.
// Reset:
//   After reset the store is cleared one cell per cycle, all MAX_CELLS cells;
//   no item is accepted during that pass, configuration writes still are.
// Stall:
//   The result register holds until taken; a read finding it still full
//   waits, holding its data, and no further item is accepted meanwhile.
// ----------------------------------------------------------------------------
module motion_vector_grid_binner_top #(
    parameter int CELL_SIZE = 16,
    parameter int MAX_CELLS = 8192
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // configuration channel
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [mvgb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [mvgb_pkg::GRID_W-1:0]          i_cfg_data,
    // input channel
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic                                 i_operation,
    input  wire logic [mvgb_pkg::COORD_W-1:0]         i_dst_x,
    input  wire logic [mvgb_pkg::COORD_W-1:0]         i_dst_y,
    input  wire logic [mvgb_pkg::BLK_W-1:0]           i_blk_w,
    input  wire logic [mvgb_pkg::BLK_W-1:0]           i_blk_h,
    input  wire logic signed [mvgb_pkg::MOTION_W-1:0] i_mv_x,
    input  wire logic signed [mvgb_pkg::MOTION_W-1:0] i_mv_y,
    input  wire logic                                 i_source_backward,
    input  wire logic [mvgb_pkg::COORD_W-1:0]         i_read_index,
    // output channel
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic [mvgb_pkg::COORD_W-1:0]              o_cell_index,
    output logic signed [mvgb_pkg::OUT_W-1:0]         o_cell_mv_x,
    output logic signed [mvgb_pkg::OUT_W-1:0]         o_cell_mv_y
);

    mvgb_pkg::t_cmd w_cmd;
    mvgb_pkg::t_sts w_sts;

    // Configuration writes complete in the cycle they are offered
    assign o_cfg_ready = 1'b1;

    // Sequencer
    mvgb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Datapath and cell store
    mvgb_datapath #(
        .CELL_SIZE (CELL_SIZE),
        .MAX_CELLS (MAX_CELLS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_operation       (i_operation),
        .i_dst_x           (i_dst_x),
        .i_dst_y           (i_dst_y),
        .i_blk_w           (i_blk_w),
        .i_blk_h           (i_blk_h),
        .i_mv_x            (i_mv_x),
        .i_mv_y            (i_mv_y),
        .i_source_backward (i_source_backward),
        .i_read_index      (i_read_index),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_cell_index      (o_cell_index),
        .o_cell_mv_x       (o_cell_mv_x),
        .o_cell_mv_y       (o_cell_mv_y)
    );

endmodule
`default_nettype wire

### src/mvgb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mvgb_ram: generic simple dual-port RAM
// One write port and one read port, read data registered and held while the
// read enable is low.
// ----------------------------------------------------------------------------
module mvgb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

### src/mvgb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mvgb_ctrl: sequencer of the motion vector grid binner
// Runs the clearing pass after reset, then steps one item at a time through
// the add or read sequence by commands to the datapath.
// ----------------------------------------------------------------------------
module mvgb_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire mvgb_pkg::t_sts i_sts,
    output mvgb_pkg::t_cmd     o_cmd
);

    mvgb_pkg::t_state r_state;
    mvgb_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mvgb_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            mvgb_pkg::S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = mvgb_pkg::S_IDLE;
                end
            end
            mvgb_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    if (i_sts.in_op == mvgb_pkg::OP_READ) begin
                        n_state = mvgb_pkg::S_RISSUE;
                    end else begin
                        n_state = mvgb_pkg::S_DIV;
                    end
                end
            end
            mvgb_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_state        = mvgb_pkg::S_FIX;
            end
            mvgb_pkg::S_FIX: begin
                o_cmd.fix_step = 1'b1;
                n_state        = mvgb_pkg::S_IDX;
            end
            mvgb_pkg::S_IDX: begin
                o_cmd.idx_step = 1'b1;
                n_state        = mvgb_pkg::S_ISSUE;
            end
            mvgb_pkg::S_ISSUE: begin
                if (i_sts.add_ok) begin
                    o_cmd.rd_add = 1'b1;
                    n_state      = mvgb_pkg::S_WR;
                end else begin
                    n_state = mvgb_pkg::S_IDLE;
                end
            end
            mvgb_pkg::S_WR: begin
                o_cmd.wr_add = 1'b1;
                n_state      = mvgb_pkg::S_IDLE;
            end
            mvgb_pkg::S_RISSUE: begin
                o_cmd.rd_cell = i_sts.ridx_ok;
                n_state       = mvgb_pkg::S_ROUT;
            end
            mvgb_pkg::S_ROUT: begin
                // hold the read data until the result register frees up
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = mvgb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mvgb_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### src/mvgb_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mvgb_datapath: datapath of the motion vector grid binner
// Cell number by reciprocal division, block weight, cell sum store with
// read-modify-write, read scaling and clamping, result register.
// ----------------------------------------------------------------------------
module mvgb_datapath #(
    parameter int CELL_SIZE = 16,
    parameter int MAX_CELLS = 8192
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire mvgb_pkg::t_cmd                      i_cmd,
    output mvgb_pkg::t_sts                           o_sts,
    // configuration writes
    input  wire logic                                i_cfg_valid,
    input  wire logic [mvgb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [mvgb_pkg::GRID_W-1:0]         i_cfg_data,
    // input item
    input  wire logic                                i_operation,
    input  wire logic [mvgb_pkg::COORD_W-1:0]        i_dst_x,
    input  wire logic [mvgb_pkg::COORD_W-1:0]        i_dst_y,
    input  wire logic [mvgb_pkg::BLK_W-1:0]          i_blk_w,
    input  wire logic [mvgb_pkg::BLK_W-1:0]          i_blk_h,
    input  wire logic signed [mvgb_pkg::MOTION_W-1:0] i_mv_x,
    input  wire logic signed [mvgb_pkg::MOTION_W-1:0] i_mv_y,
    input  wire logic                                i_source_backward,
    input  wire logic [mvgb_pkg::COORD_W-1:0]        i_read_index,
    // result item
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [mvgb_pkg::COORD_W-1:0]             o_cell_index,
    output logic signed [mvgb_pkg::OUT_W-1:0]        o_cell_mv_x,
    output logic signed [mvgb_pkg::OUT_W-1:0]        o_cell_mv_y
);

    localparam int AW      = $clog2(MAX_CELLS);
    localparam int CW      = mvgb_pkg::COORD_W;
    localparam int MW      = mvgb_pkg::MOTION_W;
    localparam int IW      = mvgb_pkg::IDX_FULL_W;
    localparam int SHIFT   = 20;
    localparam int PROD_W  = CW + SHIFT;
    // floor(2^SHIFT / CELL_SIZE): estimate is the quotient or one below it
    localparam logic [PROD_W-1:0] RECIP = PROD_W'((2 ** SHIFT) / CELL_SIZE);
    localparam logic [CW-1:0]     CSIZE = CW'(CELL_SIZE);
    localparam logic [AW-1:0]     CLR_LAST = AW'(MAX_CELLS - 1);

    // sum / 4 toward zero, clamped to +-127
    function automatic logic [mvgb_pkg::OUT_W-1:0] scale_out(input logic [MW-1:0] sum);
        logic signed [MW:0] adj;
        logic signed [MW:0] q;
        adj = $signed({sum[MW-1], sum}) + (sum[MW-1] ? 17'sd3 : 17'sd0);
        q   = adj >>> 2;
        if (q > 17'sd127) begin
            scale_out = 8'sd127;
        end else if (q < -17'sd127) begin
            scale_out = -8'sd127;
        end else begin
            scale_out = q[mvgb_pkg::OUT_W-1:0];
        end
    endfunction

    // Configuration registers
    logic [mvgb_pkg::GRID_W-1:0] r_grid_cols;
    logic [mvgb_pkg::GRID_W-1:0] r_grid_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols <= mvgb_pkg::GRID_COLS_RST;
            r_grid_rows <= mvgb_pkg::GRID_ROWS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mvgb_pkg::CFG_GRID_COLS: r_grid_cols <= i_cfg_data;
                mvgb_pkg::CFG_GRID_ROWS: r_grid_rows <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Captured item
    logic [CW-1:0]            r_dx, r_dy, r_ridx;
    logic [mvgb_pkg::BLK_W-1:0] r_bw, r_bh;
    logic [MW-1:0]            r_mx, r_my;
    logic                     r_back, r_nonzero, r_ridx_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_dx      <= i_dst_x;
            r_dy      <= i_dst_y;
            r_bw      <= i_blk_w;
            r_bh      <= i_blk_h;
            r_mx      <= i_mv_x;
            r_my      <= i_mv_y;
            r_back    <= i_source_backward;
            r_nonzero <= (i_mv_x != '0) || (i_mv_y != '0);
            r_ridx    <= i_read_index;
            r_ridx_ok <= 32'(i_read_index) < MAX_CELLS;
        end
    end

    // Divide step: quotient estimates, weight, weighted motion
    logic [PROD_W-1:0]           w_px, w_py;
    logic [2*mvgb_pkg::BLK_W-1:0] w_area;
    logic [mvgb_pkg::WEIGHT_W-1:0] w_weight;
    logic signed [MW+mvgb_pkg::WEIGHT_W:0] w_wx, w_wy;
    logic [CW-1:0]               r_q0x, r_q0y;
    logic [mvgb_pkg::WEIGHT_W-1:0] r_weight;
    logic [MW-1:0]               r_wx, r_wy;

    assign w_px     = PROD_W'(r_dx) * RECIP;
    assign w_py     = PROD_W'(r_dy) * RECIP;
    assign w_area   = (2*mvgb_pkg::BLK_W)'(r_bw) * (2*mvgb_pkg::BLK_W)'(r_bh);
    assign w_weight = w_area[2*mvgb_pkg::BLK_W-1:6];
    assign w_wx     = $signed(r_mx) * $signed({1'b0, w_weight});
    assign w_wy     = $signed(r_my) * $signed({1'b0, w_weight});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_step) begin
            r_q0x    <= w_px[PROD_W-1:SHIFT];
            r_q0y    <= w_py[PROD_W-1:SHIFT];
            r_weight <= w_weight;
            r_wx     <= w_wx[MW-1:0];
            r_wy     <= w_wy[MW-1:0];
        end
    end

    // Fix step: correct the quotient, apply the reference direction
    logic [CW-1:0] w_remx, w_remy;
    logic [CW-1:0] r_col, r_row;
    logic [MW-1:0] r_vx, r_vy;

    assign w_remx = r_dx - CW'(r_q0x * CSIZE);
    assign w_remy = r_dy - CW'(r_q0y * CSIZE);

    always_ff @(posedge i_clk) begin
        if (i_cmd.fix_step) begin
            r_col <= r_q0x + CW'(w_remx >= CSIZE);
            r_row <= r_q0y + CW'(w_remy >= CSIZE);
            r_vx  <= r_back ? (MW'(0) - r_wx) : r_wx;
            r_vy  <= r_back ? (MW'(0) - r_wy) : r_wy;
        end
    end

    // Index step: cell number and add checks
    logic [IW-1:0] w_idx_full;
    logic [AW-1:0] r_idx;
    logic          r_add_ok;

    assign w_idx_full = IW'(r_row) * IW'(r_grid_cols) + IW'(r_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_add_ok <= 1'b0;
        end else if (i_cmd.idx_step) begin
            r_add_ok <= r_nonzero && (r_weight != '0)
                        && (r_col < CW'(r_grid_cols)) && (r_row < CW'(r_grid_rows))
                        && (w_idx_full < IW'(MAX_CELLS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_step) begin
            r_idx <= AW'(w_idx_full);
        end
    end

    // Clearing pass counter
    logic [AW-1:0] r_clr_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_cnt <= r_clr_cnt + AW'(1);
        end
    end

    // Cell sum store: {sum_x, sum_y}
    logic            w_we, w_re;
    logic [AW-1:0]   w_waddr, w_raddr;
    logic [2*MW-1:0] w_wdata, w_rdata;
    logic [MW-1:0]   w_sumx, w_sumy;

    assign w_sumx  = w_rdata[2*MW-1:MW] + r_vx;
    assign w_sumy  = w_rdata[MW-1:0] + r_vy;
    assign w_we    = i_cmd.clr_wr || i_cmd.wr_add || (i_cmd.out_load && r_ridx_ok);
    assign w_re    = i_cmd.rd_add || i_cmd.rd_cell;
    assign w_raddr = i_cmd.rd_add ? r_idx : AW'(r_ridx);
    assign w_wdata = i_cmd.wr_add ? {w_sumx, w_sumy} : '0;

    always_comb begin
        if (i_cmd.clr_wr) begin
            w_waddr = r_clr_cnt;
        end else if (i_cmd.wr_add) begin
            w_waddr = r_idx;
        end else begin
            w_waddr = AW'(r_ridx);
        end
    end

    mvgb_ram #(
        .WIDTH (2 * MW),
        .DEPTH (MAX_CELLS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Result register
    logic w_out_free;

    assign w_out_free = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_cell_index <= r_ridx;
            o_cell_mv_x  <= r_ridx_ok ? scale_out(w_rdata[2*MW-1:MW]) : '0;
            o_cell_mv_y  <= r_ridx_ok ? scale_out(w_rdata[MW-1:0]) : '0;
        end
    end

    // Status to the controller
    always_comb begin
        o_sts.in_op    = i_operation;
        o_sts.add_ok   = r_add_ok;
        o_sts.ridx_ok  = r_ridx_ok;
        o_sts.clr_last = (r_clr_cnt == CLR_LAST);
        o_sts.out_free = w_out_free;
    end

    // A result is only loaded into a free result register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> w_out_free)
        else $error("result loaded over a pending result");

    // Sum write-back comes in the cycle right after its read
    a_rmw_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_add |-> $past(i_cmd.rd_add))
        else $error("sum write without a preceding read");

    // A read beyond the store leaves every cell alone
    a_oob_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && !r_ridx_ok) |-> !w_we)
        else $error("store written by an out-of-range read");

endmodule
`default_nettype wire
